FILE: hdl/sosm_pkg.sv
// ----------------------------------------------------------------------------
// sosm_pkg
// shared types, codes and sizes for the sorted sequence merger
// ----------------------------------------------------------------------------
package sosm_pkg;

	// element store depth and derived widths
	localparam int DEPTH = 32;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int RW    = CW + 1;

	// input command codes
	localparam logic [1:0] CMD_PUSH_A = 2'd0;
	localparam logic [1:0] CMD_PUSH_B = 2'd1;
	localparam logic [1:0] CMD_MERGE  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_PUSH_A,
		OP_PUSH_B,
		OP_MERGE
	} op_kind_t;

	typedef struct packed {
		op_kind_t           kind;
		logic signed [31:0] value;
	} op_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         status;
		logic               last;
	} result_t;

endpackage

FILE: hdl/sorted_sequence_merger_core.sv
// ----------------------------------------------------------------------------
// sorted_sequence_merger_core
// two-way merge of two stored sorted sequences of signed 32-bit elements
// ----------------------------------------------------------------------------
// usage:
//   input channel: command and value are taken when push is high and full is
//   low. command 0 appends value to sequence a, 1 appends to b, 2 merges;
//   command 3 is accepted and ignored.
//   result channel: merged_value, status and last hold the oldest result while
//   empty is low; pop high with empty low takes it.
// timing:
//   an append is taken by the executor and gives no result, unless
//   the store already holds 32 elements (one status 2 result, value dropped).
//   a merge takes two setup steps (taking the item, first memory read), then
//   gives one element per cycle while the result queue has space; with either
//   sequence empty it gives a single status 1 result. both counts are cleared
//   after every merge. an error result passes the operation and result queue
//   registers; a merged element also waits for the two setup steps.
// stalls:
//   a two entry operation queue and a two entry result queue sit on either
//   side of the executor, so a stalled receiver only stops the merge once the
//   result queue fills, and full rises once the operation queue fills.
// reset:
//   arst_n clears the queues and both counts; memory contents are not reset
//   and only data read below the matching count is used.
// ----------------------------------------------------------------------------
module sorted_sequence_merger_core
	import sosm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         command,
	input  logic signed [31:0] value,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] merged_value,
	output logic [1:0]         status,
	output logic               last
);

	// front to executor
	logic    op_valid;
	op_t     op;
	logic    op_take;

	// executor to result queue
	logic    res_valid;
	result_t res;
	logic    out_space;
	result_t head;

	// accept and decode items
	sosm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.command  (command),
		.value    (value),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take)
	);

	// element stores and merge engine
	sosm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.op_take   (op_take),
		.out_space (out_space),
		.res_valid (res_valid),
		.res       (res)
	);

	// results wait here for the receiver
	sosm_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.space     (out_space),
		.empty     (empty),
		.pop       (pop),
		.head      (head)
	);

	assign merged_value = head.value;
	assign status       = head.status;
	assign last         = head.last;

endmodule

FILE: hdl/sosm_ram.sv
// ----------------------------------------------------------------------------
// sosm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module sosm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/sosm_front.sv
// ----------------------------------------------------------------------------
// sosm_front
// accepts items, decodes the command and queues operations for the back end
// ----------------------------------------------------------------------------
module sosm_front
	import sosm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic signed [31:0] value,
	output logic        op_valid,
	output op_t         op,
	input  logic        op_take
);

	op_t        queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	logic       accept;
	logic       enq;
	logic       deq;
	op_t        op_in;

	assign full     = (cnt_q == 2'd2);
	assign accept   = push && !full;
	assign op_valid = (cnt_q != 2'd0);
	assign op       = queue_q[rd_ptr_q];
	assign deq      = op_take && op_valid;

	// unused command code is dropped here
	always_comb begin
		op_in.value = value;
		op_in.kind  = OP_MERGE;
		enq         = 1'b0;
		case (command)
			CMD_PUSH_A: begin
				op_in.kind = OP_PUSH_A;
				enq        = accept;
			end
			CMD_PUSH_B: begin
				op_in.kind = OP_PUSH_B;
				enq        = accept;
			end
			CMD_MERGE: begin
				op_in.kind = OP_MERGE;
				enq        = accept;
			end
			default: begin
				enq = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			queue_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!enq && deq) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: hdl/sosm_outq.sv
// ----------------------------------------------------------------------------
// sosm_outq
// two entry result queue that decouples the merge engine from the receiver
// ----------------------------------------------------------------------------
module sosm_outq
	import sosm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    space,
	output logic    empty,
	input  logic    pop,
	output result_t head
);

	result_t    queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	logic       enq;
	logic       deq;

	assign space = (cnt_q != 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = queue_q[rd_ptr_q];
	assign enq   = res_valid && space;
	assign deq   = pop && !empty;

	always_ff @(posedge clk) begin
		if (enq) begin
			queue_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!enq && deq) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: hdl/sosm_back.sv
// ----------------------------------------------------------------------------
// sosm_back
// executes queued operations: stores elements and runs the two-way merge
// ----------------------------------------------------------------------------
module sosm_back
	import sosm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    op_valid,
	input  op_t     op,
	output logic    op_take,
	input  logic    out_space,
	output logic    res_valid,
	output result_t res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_MERGE
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  ca_q;
	logic [CW-1:0]  cb_q;
	logic [CW-1:0]  ia_q;
	logic [CW-1:0]  ib_q;
	logic [RW-1:0]  rem_q;

	logic [CW-1:0]  ia_nxt;
	logic [CW-1:0]  ib_nxt;
	logic           we_a;
	logic           we_b;
	logic [AW-1:0]  raddr_a;
	logic [AW-1:0]  raddr_b;
	logic [31:0]    rdata_a;
	logic [31:0]    rdata_b;
	logic           a_left;
	logic           b_left;
	logic           take_a;
	logic           step;
	logic           full_a;
	logic           full_b;
	logic           none;

	assign full_a = (ca_q == CW'(DEPTH));
	assign full_b = (cb_q == CW'(DEPTH));
	assign none   = (ca_q == '0) || (cb_q == '0);
	assign ia_nxt = ia_q + CW'(1);
	assign ib_nxt = ib_q + CW'(1);
	assign a_left = (ia_q < ca_q);
	assign b_left = (ib_q < cb_q);
	// ties go to b
	assign take_a = a_left && (!b_left || ($signed(rdata_a) < $signed(rdata_b)));

	// read address runs one step ahead so the heads are ready each cycle
	assign raddr_a = (step && take_a)  ? ia_nxt[AW-1:0] : ia_q[AW-1:0];
	assign raddr_b = (step && !take_a) ? ib_nxt[AW-1:0] : ib_q[AW-1:0];

	sosm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (ca_q[AW-1:0]),
		.wdata (op.value),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	sosm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cb_q[AW-1:0]),
		.wdata (op.value),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	always_comb begin
		op_take    = 1'b0;
		res_valid  = 1'b0;
		res.value  = '0;
		res.status = ST_OK;
		res.last   = 1'b1;
		we_a       = 1'b0;
		we_b       = 1'b0;
		step       = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (op_valid) begin
					case (op.kind)
						OP_PUSH_A: begin
							if (full_a) begin
								res.status = ST_FULL;
								res_valid  = out_space;
								op_take    = out_space;
							end else begin
								we_a    = 1'b1;
								op_take = 1'b1;
							end
						end
						OP_PUSH_B: begin
							if (full_b) begin
								res.status = ST_FULL;
								res_valid  = out_space;
								op_take    = out_space;
							end else begin
								we_b    = 1'b1;
								op_take = 1'b1;
							end
						end
						OP_MERGE: begin
							if (none) begin
								res.status = ST_EMPTY;
								res_valid  = out_space;
								op_take    = out_space;
							end else begin
								op_take = 1'b1;
							end
						end
						default: begin
							op_take = 1'b0;
						end
					endcase
				end
			end
			S_MERGE: begin
				if (out_space) begin
					step      = 1'b1;
					res_valid = 1'b1;
					res.value = take_a ? rdata_a : rdata_b;
					res.last  = (rem_q == RW'(1));
				end
			end
			default: begin
				step = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ca_q    <= '0;
			cb_q    <= '0;
			ia_q    <= '0;
			ib_q    <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (op_take) begin
						case (op.kind)
							OP_PUSH_A: begin
								if (!full_a) begin
									ca_q <= ca_q + CW'(1);
								end
							end
							OP_PUSH_B: begin
								if (!full_b) begin
									cb_q <= cb_q + CW'(1);
								end
							end
							OP_MERGE: begin
								if (none) begin
									ca_q <= '0;
									cb_q <= '0;
								end else begin
									ia_q    <= '0;
									ib_q    <= '0;
									rem_q   <= RW'(ca_q) + RW'(cb_q);
									state_q <= S_PREP;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_PREP: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					if (step) begin
						if (take_a) begin
							ia_q <= ia_nxt;
						end else begin
							ib_q <= ib_nxt;
						end
						rem_q <= rem_q - RW'(1);
						if (rem_q == RW'(1)) begin
							ca_q    <= '0;
							cb_q    <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
